>>> hdl/aabb_affine_transform_macros.svh
// assertion helpers for the box transform checker
`ifndef AABB_AFFINE_TRANSFORM_MACROS_SVH
`define AABB_AFFINE_TRANSFORM_MACROS_SVH

// same-cycle implication
`define AAT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/aat_pkg.sv
package aat_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int ROW_W     = 64;
    localparam int NUM_AXES  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_Z = 2'd2;

    // identity at twelve fraction bits
    localparam logic [ROW_W-1:0] ROW_X_RESET = 64'h0000_0000_0000_1000;
    localparam logic [ROW_W-1:0] ROW_Y_RESET = 64'h0000_0000_1000_0000;
    localparam logic [ROW_W-1:0] ROW_Z_RESET = 64'h0000_1000_0000_0000;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_stage_en;

endpackage

>>> hdl/aabb_affine_transform.sv
// channel   | direction | handshake                    | payload
// s_axis    | in        | s_axis_tvalid/s_axis_tready  | box min xyz, box max xyz
// m_axis    | out       | m_axis_tvalid/m_axis_tready  | out min xyz, out max xyz, clipped
// cfg       | in        | i_cfg_valid/o_cfg_ready      | register index, 64-bit row
//
// four register stages: products, pair ordering, sums, rounding and saturation
// one register stage per step; one item per cycle sustained while the output is not stalled
// synchronous active-low reset clears the valid bits and loads the identity rows
// a stalled output holds; stages with bubbles keep filling under a stall
// cfg is always ready; the user must change rows only while the pipeline is empty, the block does not enforce it
module aabb_affine_transform #(
    parameter int COORD_WIDTH    = 16,
    parameter int COEF_FRAC_BITS = 12,
    localparam int DATA_W        = ((6 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
    input  logic [DATA_W-1:0]             s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z
    output logic [DATA_W-1:0]             m_axis_tdata,
    // clipped
    output logic                          m_axis_tuser,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [aat_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [aat_pkg::ROW_W-1:0]     i_cfg_data
);

    localparam int AX = aat_pkg::NUM_AXES;

    logic [aat_pkg::ROW_W-1:0]     r_row [AX];
    logic                          r_v1, r_v2, r_v3, r_v4;
    logic                          n_v1, n_v2, n_v3, n_v4;
    logic                          rdy1, rdy2, rdy3, rdy4;
    aat_pkg::t_stage_en            en;
    logic signed [COORD_WIDTH-1:0] box_min [AX];
    logic signed [COORD_WIDTH-1:0] box_max [AX];
    logic signed [COORD_WIDTH-1:0] res_lo [AX];
    logic signed [COORD_WIDTH-1:0] res_hi [AX];
    logic [AX-1:0]                 res_clip;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= aat_pkg::ROW_X_RESET;
            r_row[1] <= aat_pkg::ROW_Y_RESET;
            r_row[2] <= aat_pkg::ROW_Z_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                aat_pkg::CFG_ROW_X: begin
                    r_row[0] <= i_cfg_data;
                end
                aat_pkg::CFG_ROW_Y: begin
                    r_row[1] <= i_cfg_data;
                end
                aat_pkg::CFG_ROW_Z: begin
                    r_row[2] <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // a stage moves when it is empty or the one after it moves
    always_comb begin
        rdy4 = !r_v4 || m_axis_tready;
        rdy3 = !r_v3 || rdy4;
        rdy2 = !r_v2 || rdy3;
        rdy1 = !r_v1 || rdy2;
        n_v1 = rdy1 ? s_axis_tvalid : r_v1;
        n_v2 = rdy2 ? r_v1 : r_v2;
        n_v3 = rdy3 ? r_v2 : r_v3;
        n_v4 = rdy4 ? r_v3 : r_v4;
        en.s1 = rdy1;
        en.s2 = rdy2;
        en.s3 = rdy3;
        en.s4 = rdy4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
            r_v4 <= n_v4;
        end
    end

    always_comb begin
        for (int j = 0; j < AX; j++) begin
            box_min[j] = s_axis_tdata[j*COORD_WIDTH +: COORD_WIDTH];
            box_max[j] = s_axis_tdata[(AX+j)*COORD_WIDTH +: COORD_WIDTH];
        end
    end

    for (genvar i = 0; i < AX; i++) begin : g_row
        aat_row #(
            .COORD_WIDTH   (COORD_WIDTH),
            .COEF_FRAC_BITS(COEF_FRAC_BITS)
        ) u_row (
            .i_clk (i_clk),
            .i_en  (en),
            .i_row (r_row[i]),
            .i_min (box_min),
            .i_max (box_max),
            .o_lo  (res_lo[i]),
            .o_hi  (res_hi[i]),
            .o_clip(res_clip[i])
        );
    end

    always_comb begin
        m_axis_tdata = '0;
        for (int i = 0; i < AX; i++) begin
            m_axis_tdata[i*COORD_WIDTH +: COORD_WIDTH]      = res_lo[i];
            m_axis_tdata[(AX+i)*COORD_WIDTH +: COORD_WIDTH] = res_hi[i];
        end
    end

    assign m_axis_tuser  = |res_clip;
    assign m_axis_tvalid = r_v4;
    assign s_axis_tready = rdy1;

endmodule

>>> hdl/aat_row.sv
module aat_row #(
    parameter int COORD_WIDTH    = 16,
    parameter int COEF_FRAC_BITS = 12
) (
    input  logic                          i_clk,
    input  aat_pkg::t_stage_en            i_en,
    input  logic [aat_pkg::ROW_W-1:0]     i_row,
    input  logic signed [COORD_WIDTH-1:0] i_min [aat_pkg::NUM_AXES],
    input  logic signed [COORD_WIDTH-1:0] i_max [aat_pkg::NUM_AXES],
    output logic signed [COORD_WIDTH-1:0] o_lo,
    output logic signed [COORD_WIDTH-1:0] o_hi,
    output logic                          o_clip
);

    localparam int PROD_W = COORD_WIDTH + 16;
    localparam int WIDE_W = (PROD_W > COEF_FRAC_BITS + 16) ? PROD_W : COEF_FRAC_BITS + 16;
    localparam int ACC_W  = WIDE_W + 3;
    localparam int RES_W  = ACC_W - COEF_FRAC_BITS;
    localparam logic signed [RES_W-1:0] SAT_HI =
        (RES_W'(1) <<< (COORD_WIDTH - 1)) - RES_W'(1);
    localparam logic signed [RES_W-1:0] SAT_LO = -(RES_W'(1) <<< (COORD_WIDTH - 1));

    function automatic logic [COORD_WIDTH:0] clamp(input logic signed [RES_W-1:0] v);
        logic [COORD_WIDTH:0] res;
        if (v > SAT_HI) begin
            res = {1'b1, SAT_HI[COORD_WIDTH-1:0]};
        end else if (v < SAT_LO) begin
            res = {1'b1, SAT_LO[COORD_WIDTH-1:0]};
        end else begin
            res = {1'b0, v[COORD_WIDTH-1:0]};
        end
        return res;
    endfunction

    logic signed [15:0]       coef [aat_pkg::NUM_AXES];
    logic signed [15:0]       trans;
    logic signed [ACC_W-1:0]  base;

    logic signed [PROD_W-1:0] r_pa [aat_pkg::NUM_AXES];
    logic signed [PROD_W-1:0] r_pb [aat_pkg::NUM_AXES];
    logic signed [PROD_W-1:0] r_lo_t [aat_pkg::NUM_AXES];
    logic signed [PROD_W-1:0] r_hi_t [aat_pkg::NUM_AXES];
    logic signed [ACC_W-1:0]  r_lo_acc, n_lo_acc;
    logic signed [ACC_W-1:0]  r_hi_acc, n_hi_acc;
    logic signed [RES_W-1:0]  lo_round, hi_round;
    logic [COORD_WIDTH:0]     lo_sat, hi_sat;
    logic signed [COORD_WIDTH-1:0] r_lo, r_hi;
    logic                     r_clip;

    always_comb begin
        for (int j = 0; j < aat_pkg::NUM_AXES; j++) begin
            coef[j] = i_row[16*j +: 16];
        end
        trans = i_row[63:48];
        base  = (ACC_W'(trans) <<< COEF_FRAC_BITS) + (ACC_W'(1) <<< (COEF_FRAC_BITS - 1));
    end

    // products
    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            for (int j = 0; j < aat_pkg::NUM_AXES; j++) begin
                r_pa[j] <= coef[j] * i_min[j];
                r_pb[j] <= coef[j] * i_max[j];
            end
        end
    end

    // order each product pair
    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            for (int j = 0; j < aat_pkg::NUM_AXES; j++) begin
                if (r_pa[j] < r_pb[j]) begin
                    r_lo_t[j] <= r_pa[j];
                    r_hi_t[j] <= r_pb[j];
                end else begin
                    r_lo_t[j] <= r_pb[j];
                    r_hi_t[j] <= r_pa[j];
                end
            end
        end
    end

    // sums, with the rounding half folded into the base
    always_comb begin
        n_lo_acc = ACC_W'(r_lo_t[0]) + ACC_W'(r_lo_t[1]) + ACC_W'(r_lo_t[2]) + base;
        n_hi_acc = ACC_W'(r_hi_t[0]) + ACC_W'(r_hi_t[1]) + ACC_W'(r_hi_t[2]) + base;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_lo_acc <= n_lo_acc;
            r_hi_acc <= n_hi_acc;
        end
    end

    // floor shift and saturation
    always_comb begin
        lo_round = RES_W'(r_lo_acc >>> COEF_FRAC_BITS);
        hi_round = RES_W'(r_hi_acc >>> COEF_FRAC_BITS);
        lo_sat   = clamp(lo_round);
        hi_sat   = clamp(hi_round);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_lo   <= lo_sat[COORD_WIDTH-1:0];
            r_hi   <= hi_sat[COORD_WIDTH-1:0];
            r_clip <= lo_sat[COORD_WIDTH] | hi_sat[COORD_WIDTH];
        end
    end

    assign o_lo   = r_lo;
    assign o_hi   = r_hi;
    assign o_clip = r_clip;

endmodule

>>> hdl/aat_checker.sv
`include "aabb_affine_transform_macros.svh"

module aat_checker #(
    parameter int COORD_WIDTH = 16,
    parameter int DATA_W      = 96
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [DATA_W-1:0] m_axis_tdata,
    input logic              m_axis_tuser
);

    logic signed [COORD_WIDTH-1:0] min_x, min_y, min_z, max_x, max_y, max_z;

    assign min_x = m_axis_tdata[0*COORD_WIDTH +: COORD_WIDTH];
    assign min_y = m_axis_tdata[1*COORD_WIDTH +: COORD_WIDTH];
    assign min_z = m_axis_tdata[2*COORD_WIDTH +: COORD_WIDTH];
    assign max_x = m_axis_tdata[3*COORD_WIDTH +: COORD_WIDTH];
    assign max_y = m_axis_tdata[4*COORD_WIDTH +: COORD_WIDTH];
    assign max_z = m_axis_tdata[5*COORD_WIDTH +: COORD_WIDTH];

    // bounds never cross, whatever the box or the rows
    `AAT_ASSERT_NOW(a_order_x, i_clk, i_rst_n, m_axis_tvalid, min_x <= max_x, "x min above x max")
    `AAT_ASSERT_NOW(a_order_y, i_clk, i_rst_n, m_axis_tvalid, min_y <= max_y, "y min above y max")
    `AAT_ASSERT_NOW(a_order_z, i_clk, i_rst_n, m_axis_tvalid, min_z <= max_z, "z min above z max")

    `AAT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled item changed")

endmodule

bind aabb_affine_transform aat_checker #(
    .COORD_WIDTH(COORD_WIDTH),
    .DATA_W     (DATA_W)
) u_aat_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);
